// ===== design/refcounted_chunk_cache_manager_assert.svh =====
// Assertion macros used by the chunk cache manager datapath.
`ifndef REFCOUNTED_CHUNK_CACHE_MANAGER_ASSERT_SVH
`define REFCOUNTED_CHUNK_CACHE_MANAGER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define RCCM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define RCCM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RCCM_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define RCCM_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== design/rccm_pkg.sv =====
// Shared types and codes of the chunk cache manager.
`default_nettype none
package rccm_pkg;

    typedef enum logic [1:0] {
        MODE_REQUEST = 2'd0,
        MODE_TAKE    = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_ABANDON = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_READY_HIT   = 3'd0,
        ST_PENDING_HIT = 3'd1,
        ST_MISS_ALLOC  = 3'd2,
        ST_NO_SPACE    = 3'd3,
        ST_DONE        = 3'd4,
        ST_INVALID     = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLR,
        OP_LOAD,
        OP_SCAN,
        OP_IDRD,
        OP_IDCHK,
        OP_LRD,
        OP_LRM,
        OP_EVRM,
        OP_AP1,
        OP_AP2,
        OP_INC,
        OP_DEC,
        OP_FREE,
        OP_ALRD,
        OP_ALWR,
        OP_EVRD,
        OP_EVAL,
        OP_RES
    } op_t;

    typedef enum logic [1:0] {
        SEL_TGT  = 2'd0,
        SEL_IDX  = 2'd1,
        SEL_ZERO = 2'd2
    } slot_sel_t;

    typedef enum logic {
        REFS_CNT  = 1'b0,
        REFS_ZERO = 1'b1
    } refs_sel_t;

    typedef struct packed {
        op_t       op;
        status_t   res_status;
        slot_sel_t slot_sel;
        refs_sel_t refs_sel;
    } cmd_t;

    typedef struct packed {
        logic  clr_last;
        logic  scan_hit;
        logic  scan_end;
        logic  in_range;
        mode_t mode;
        logic  free_empty;
        logic  lru_empty;
        logic  used;
        logic  ref_zero;
        logic  ref_one;
        logic  ref_two;
        logic  ref_max;
        logic  out_busy;
    } stat_t;

endpackage
`default_nettype wire

// ===== design/refcounted_chunk_cache_manager.sv =====
// Top level of the reference-counted chunk cache slot manager.
// A slot transaction (take, release, abandon) reads and checks its slot, then updates the
// count and the LRU or free list before its result. A key request scans the slot table until
// a hit; a miss scans all NUM_SLOTS slots, then takes a free slot or evicts the oldest idle one.
// Throughput: one transaction at a time; the sequential key scan of the slot table sets it.
// Reset: asynchronous, active low; stall stays high through a clearing pass over all slots.
`default_nettype none
module refcounted_chunk_cache_manager #(
    parameter int NUM_SLOTS = 256,
    parameter int KEY_BITS  = 24,
    parameter int REF_BITS  = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [1:0]  mode,
    input  wire  [23:0] chunk_key,
    input  wire  [7:0]  slot_index,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [2:0]  status,
    output logic [7:0]  slot_out,
    output logic [15:0] ref_out,
    output logic        evicted,
    output logic [23:0] evicted_key
);
    // The controller walks each transaction through a sequence of datapath
    // operations; the datapath owns the slot, free-list and LRU tables and
    // reports flags back. The result register frees the input side: a new
    // transaction is taken while the last result still waits downstream.
    rccm_pkg::cmd_t  cmd;
    rccm_pkg::stat_t st;

    rccm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    rccm_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .KEY_BITS  (KEY_BITS),
        .REF_BITS  (REF_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .mode        (mode),
        .chunk_key   (chunk_key),
        .slot_index  (slot_index),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .status      (status),
        .slot_out    (slot_out),
        .ref_out     (ref_out),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );
endmodule
`default_nettype wire

// ===== design/rccm_datapath.sv =====
// Slot tables, list pointers and result register of the chunk cache manager.
`default_nettype none
`include "refcounted_chunk_cache_manager_assert.svh"
module rccm_datapath #(
    parameter int NUM_SLOTS = 256,
    parameter int KEY_BITS  = 24,
    parameter int REF_BITS  = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  rccm_pkg::cmd_t        cmd,
    output rccm_pkg::stat_t       st,
    input  wire  [1:0]            mode,
    input  wire  [23:0]           chunk_key,
    input  wire  [7:0]            slot_index,
    input  wire                   out_stall,
    output logic                  out_valid,
    output logic [2:0]            status,
    output logic [7:0]            slot_out,
    output logic [15:0]           ref_out,
    output logic                  evicted,
    output logic [23:0]           evicted_key
);
    localparam int SB = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PW = SB + 1;
    localparam int IW = (PW > 8) ? PW : 8;
    localparam int WW = 1 + REF_BITS + KEY_BITS;
    localparam logic [PW-1:0] NIL = PW'(NUM_SLOTS);
    localparam logic [SB-1:0] LAST = SB'(NUM_SLOTS - 1);
    localparam logic [REF_BITS-1:0] RMAX = '1;

    logic [WW-1:0] slot_mem  [NUM_SLOTS];
    logic [PW-1:0] fnext_mem [NUM_SLOTS];
    logic [PW-1:0] lprev_mem [NUM_SLOTS];
    logic [PW-1:0] lnext_mem [NUM_SLOTS];

    rccm_pkg::mode_t      mode_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [IW-1:0]        idx_reg;
    logic [PW-1:0]        cnt_reg;
    logic                 scan_vld_reg;
    logic [WW-1:0]        slot_rd_reg;
    logic [SB-1:0]        slot_addr_reg;
    logic [PW-1:0]        fn_rd_reg;
    logic [PW-1:0]        lp_rd_reg;
    logic [PW-1:0]        ln_rd_reg;
    logic [SB-1:0]        tgt_reg;
    logic [REF_BITS-1:0]  refs_reg;
    logic                 used_reg;
    logic [PW-1:0]        free_head_reg;
    logic [PW-1:0]        lru_head_reg;
    logic [PW-1:0]        lru_tail_reg;
    logic                 ev_reg;
    logic [KEY_BITS-1:0]  evk_reg;
    logic                 out_valid_reg;
    rccm_pkg::status_t    out_status_reg;
    logic [7:0]           out_slot_reg;
    logic [15:0]          out_refs_reg;
    logic                 out_ev_reg;
    logic [23:0]          out_evk_reg;

    logic                 q_used;
    logic [REF_BITS-1:0]  q_refs;
    logic [KEY_BITS-1:0]  q_key;
    logic [REF_BITS-1:0]  refs_inc;
    logic [REF_BITS-1:0]  refs_dec;
    logic                 hit;
    logic                 slot_we;
    logic [SB-1:0]        slot_wa;
    logic [WW-1:0]        slot_wd;
    logic [SB-1:0]        slot_ra;
    logic                 fn_we;
    logic [SB-1:0]        fn_wa;
    logic [PW-1:0]        fn_wd;
    logic [SB-1:0]        fn_ra;
    logic                 lp_we;
    logic [SB-1:0]        lp_wa;
    logic [PW-1:0]        lp_wd;
    logic                 ln_we;
    logic [SB-1:0]        ln_wa;
    logic [PW-1:0]        ln_wd;
    logic [SB-1:0]        l_ra;

    assign q_used   = slot_rd_reg[WW-1];
    assign q_refs   = slot_rd_reg[KEY_BITS +: REF_BITS];
    assign q_key    = slot_rd_reg[KEY_BITS-1:0];
    assign refs_inc = refs_reg + 1'b1;
    assign refs_dec = refs_reg - 1'b1;
    assign hit      = (cmd.op == rccm_pkg::OP_SCAN) && scan_vld_reg && q_used
                      && (q_key == key_reg);

    always_comb
    begin
        st.clr_last   = (cnt_reg[SB-1:0] == LAST);
        st.scan_hit   = hit;
        st.scan_end   = (cmd.op == rccm_pkg::OP_SCAN) && scan_vld_reg && !hit
                        && (slot_addr_reg == LAST);
        st.in_range   = (idx_reg < IW'(NUM_SLOTS));
        st.mode       = mode_reg;
        st.free_empty = (free_head_reg == NIL);
        st.lru_empty  = (lru_head_reg == NIL);
        st.used       = used_reg;
        st.ref_zero   = (refs_reg == '0);
        st.ref_one    = (refs_reg == REF_BITS'(1));
        st.ref_two    = (refs_reg == REF_BITS'(2));
        st.ref_max    = (refs_reg == RMAX);
        st.out_busy   = out_valid_reg && out_stall;
    end

    // Memory port decode per operation
    always_comb
    begin
        slot_we = 1'b0;
        slot_wa = tgt_reg;
        slot_wd = {1'b1, REF_BITS'(0), key_reg};
        slot_ra = tgt_reg;
        fn_we   = 1'b0;
        fn_wa   = tgt_reg;
        fn_wd   = free_head_reg;
        fn_ra   = free_head_reg[SB-1:0];
        lp_we   = 1'b0;
        lp_wa   = tgt_reg;
        lp_wd   = lru_tail_reg;
        ln_we   = 1'b0;
        ln_wa   = tgt_reg;
        ln_wd   = NIL;
        l_ra    = tgt_reg;
        case (cmd.op)
            rccm_pkg::OP_CLR:
            begin
                slot_we = 1'b1;
                slot_wa = cnt_reg[SB-1:0];
                slot_wd = '0;
                fn_we   = 1'b1;
                fn_wa   = cnt_reg[SB-1:0];
                fn_wd   = cnt_reg + 1'b1;
            end
            rccm_pkg::OP_SCAN:
            begin
                slot_ra = (cnt_reg < NIL) ? cnt_reg[SB-1:0] : '0;
            end
            rccm_pkg::OP_IDRD:
            begin
                slot_ra = idx_reg[SB-1:0];
            end
            rccm_pkg::OP_LRM, rccm_pkg::OP_EVRM:
            begin
                ln_we = (lp_rd_reg != NIL);
                ln_wa = lp_rd_reg[SB-1:0];
                ln_wd = ln_rd_reg;
                lp_we = (ln_rd_reg != NIL);
                lp_wa = ln_rd_reg[SB-1:0];
                lp_wd = lp_rd_reg;
            end
            rccm_pkg::OP_AP1:
            begin
                ln_we = 1'b1;
                lp_we = 1'b1;
            end
            rccm_pkg::OP_AP2:
            begin
                ln_we = (lru_tail_reg != NIL);
                ln_wa = lru_tail_reg[SB-1:0];
                ln_wd = PW'(tgt_reg);
            end
            rccm_pkg::OP_INC:
            begin
                slot_we = 1'b1;
                slot_wd = {1'b1, refs_inc, key_reg};
            end
            rccm_pkg::OP_DEC:
            begin
                slot_we = 1'b1;
                slot_wd = {1'b1, refs_dec, key_reg};
            end
            rccm_pkg::OP_FREE:
            begin
                slot_we = 1'b1;
                slot_wd = {1'b0, REF_BITS'(0), key_reg};
                fn_we   = 1'b1;
            end
            rccm_pkg::OP_ALWR:
            begin
                slot_we = 1'b1;
                slot_wa = free_head_reg[SB-1:0];
            end
            rccm_pkg::OP_EVAL:
            begin
                slot_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_wa] <= slot_wd;
        slot_rd_reg   <= slot_mem[slot_ra];
        slot_addr_reg <= slot_ra;
        if (fn_we)
            fnext_mem[fn_wa] <= fn_wd;
        fn_rd_reg <= fnext_mem[fn_ra];
        if (lp_we)
            lprev_mem[lp_wa] <= lp_wd;
        lp_rd_reg <= lprev_mem[l_ra];
        if (ln_we)
            lnext_mem[ln_wa] <= ln_wd;
        ln_rd_reg <= lnext_mem[l_ra];
    end

    // Control registers: counters, list heads, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            scan_vld_reg  <= 1'b0;
            free_head_reg <= '0;
            lru_head_reg  <= NIL;
            lru_tail_reg  <= NIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= (cmd.op == rccm_pkg::OP_SCAN);
            if (cmd.op == rccm_pkg::OP_RES)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                rccm_pkg::OP_CLR, rccm_pkg::OP_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                rccm_pkg::OP_LOAD:
                begin
                    cnt_reg <= '0;
                end
                rccm_pkg::OP_LRM, rccm_pkg::OP_EVRM:
                begin
                    if (lp_rd_reg == NIL)
                        lru_head_reg <= ln_rd_reg;
                    if (ln_rd_reg == NIL)
                        lru_tail_reg <= lp_rd_reg;
                end
                rccm_pkg::OP_AP2:
                begin
                    if (lru_tail_reg == NIL)
                        lru_head_reg <= PW'(tgt_reg);
                    lru_tail_reg <= PW'(tgt_reg);
                end
                rccm_pkg::OP_FREE:
                begin
                    free_head_reg <= PW'(tgt_reg);
                end
                rccm_pkg::OP_ALWR:
                begin
                    free_head_reg <= fn_rd_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            rccm_pkg::OP_LOAD:
            begin
                mode_reg <= rccm_pkg::mode_t'(mode);
                key_reg  <= KEY_BITS'(chunk_key);
                idx_reg  <= IW'(slot_index);
                ev_reg   <= 1'b0;
                evk_reg  <= '0;
            end
            rccm_pkg::OP_SCAN:
            begin
                if (hit)
                begin
                    tgt_reg  <= slot_addr_reg;
                    refs_reg <= q_refs;
                end
            end
            rccm_pkg::OP_IDCHK:
            begin
                tgt_reg  <= idx_reg[SB-1:0];
                refs_reg <= q_refs;
                used_reg <= q_used;
                key_reg  <= q_key;
            end
            rccm_pkg::OP_INC:
            begin
                refs_reg <= refs_inc;
            end
            rccm_pkg::OP_DEC:
            begin
                refs_reg <= refs_dec;
            end
            rccm_pkg::OP_FREE:
            begin
                refs_reg <= '0;
            end
            rccm_pkg::OP_ALWR:
            begin
                tgt_reg <= free_head_reg[SB-1:0];
            end
            rccm_pkg::OP_EVRD:
            begin
                tgt_reg <= lru_head_reg[SB-1:0];
            end
            rccm_pkg::OP_EVRM:
            begin
                ev_reg  <= 1'b1;
                evk_reg <= q_key;
            end
            rccm_pkg::OP_RES:
            begin
                out_status_reg <= cmd.res_status;
                case (cmd.slot_sel)
                    rccm_pkg::SEL_TGT:  out_slot_reg <= 8'(tgt_reg);
                    rccm_pkg::SEL_IDX:  out_slot_reg <= idx_reg[7:0];
                    default:            out_slot_reg <= '0;
                endcase
                out_refs_reg <= (cmd.refs_sel == rccm_pkg::REFS_CNT) ? 16'(refs_reg) : '0;
                out_ev_reg   <= ev_reg;
                out_evk_reg  <= 24'(evk_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot_out    = out_slot_reg;
    assign ref_out     = out_refs_reg;
    assign evicted     = out_ev_reg;
    assign evicted_key = out_evk_reg;

    `RCCM_ASSERT_IMP(a_lru_ends, clk, rst_n, 1'b1, (lru_head_reg == NIL) == (lru_tail_reg == NIL))
    `RCCM_ASSERT_IMP(a_free_head, clk, rst_n, 1'b1, free_head_reg <= NIL)
    `RCCM_ASSERT_IMP(a_res_free, clk, rst_n, cmd.op == rccm_pkg::OP_RES, !(out_valid_reg && out_stall))
    `RCCM_ASSERT_IMP(a_inc_room, clk, rst_n, cmd.op == rccm_pkg::OP_INC, refs_reg != RMAX)
    `RCCM_ASSERT_IMP(a_dec_room, clk, rst_n, cmd.op == rccm_pkg::OP_DEC, refs_reg != '0)
endmodule
`default_nettype wire

// ===== design/rccm_ctrl.sv =====
// Sequencer of the chunk cache manager: issues at most one datapath operation a cycle.
`default_nettype none
module rccm_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  rccm_pkg::stat_t     st,
    output rccm_pkg::cmd_t      cmd
);
    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP, S_SCAN, S_HIT, S_MISS, S_ALRD, S_ALWR,
        S_EVRD, S_EVLR, S_EVRM, S_EVAL, S_IDRD, S_IDCHK, S_IDOP,
        S_INC, S_DEC, S_AP1, S_AP2, S_LRD, S_LRM, S_FREE, S_RES
    } state_t;

    state_t                  state_reg, state_next;
    rccm_pkg::status_t       res_status_reg, res_status_next;
    rccm_pkg::slot_sel_t     slot_sel_reg, slot_sel_next;
    rccm_pkg::refs_sel_t     refs_sel_reg, refs_sel_next;
    logic                    free_after_reg, free_after_next;
    rccm_pkg::op_t           op;

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        slot_sel_next   = slot_sel_reg;
        refs_sel_next   = refs_sel_reg;
        free_after_next = free_after_reg;
        op              = rccm_pkg::OP_NOP;
        case (state_reg)
            S_CLR:
            begin
                op = rccm_pkg::OP_CLR;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = rccm_pkg::OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (st.mode == rccm_pkg::MODE_REQUEST)
                    state_next = S_SCAN;
                else if (!st.in_range)
                begin
                    res_status_next = rccm_pkg::ST_INVALID;
                    slot_sel_next   = rccm_pkg::SEL_IDX;
                    refs_sel_next   = rccm_pkg::REFS_ZERO;
                    state_next      = S_RES;
                end
                else
                    state_next = S_IDRD;
            end
            S_SCAN:
            begin
                op = rccm_pkg::OP_SCAN;
                if (st.scan_hit)
                    state_next = S_HIT;
                else if (st.scan_end)
                    state_next = S_MISS;
            end
            S_HIT:
            begin
                slot_sel_next = rccm_pkg::SEL_TGT;
                refs_sel_next = rccm_pkg::REFS_CNT;
                if (st.ref_zero)
                begin
                    res_status_next = rccm_pkg::ST_PENDING_HIT;
                    state_next      = S_RES;
                end
                else if (st.ref_max)
                begin
                    res_status_next = rccm_pkg::ST_NO_SPACE;
                    state_next      = S_RES;
                end
                else
                begin
                    res_status_next = rccm_pkg::ST_READY_HIT;
                    state_next      = S_INC;
                end
            end
            S_MISS:
            begin
                if (!st.free_empty)
                    state_next = S_ALRD;
                else if (!st.lru_empty)
                    state_next = S_EVRD;
                else
                begin
                    res_status_next = rccm_pkg::ST_NO_SPACE;
                    slot_sel_next   = rccm_pkg::SEL_ZERO;
                    refs_sel_next   = rccm_pkg::REFS_ZERO;
                    state_next      = S_RES;
                end
            end
            S_ALRD:
            begin
                op         = rccm_pkg::OP_ALRD;
                state_next = S_ALWR;
            end
            S_ALWR, S_EVAL:
            begin
                op              = (state_reg == S_ALWR) ? rccm_pkg::OP_ALWR
                                                        : rccm_pkg::OP_EVAL;
                res_status_next = rccm_pkg::ST_MISS_ALLOC;
                slot_sel_next   = rccm_pkg::SEL_TGT;
                refs_sel_next   = rccm_pkg::REFS_ZERO;
                state_next      = S_RES;
            end
            S_EVRD:
            begin
                op         = rccm_pkg::OP_EVRD;
                state_next = S_EVLR;
            end
            S_EVLR:
            begin
                op         = rccm_pkg::OP_LRD;
                state_next = S_EVRM;
            end
            S_EVRM:
            begin
                op         = rccm_pkg::OP_EVRM;
                state_next = S_EVAL;
            end
            S_IDRD:
            begin
                op         = rccm_pkg::OP_IDRD;
                state_next = S_IDCHK;
            end
            S_IDCHK:
            begin
                op         = rccm_pkg::OP_IDCHK;
                state_next = S_IDOP;
            end
            S_IDOP:
            begin
                res_status_next = rccm_pkg::ST_DONE;
                slot_sel_next   = rccm_pkg::SEL_TGT;
                refs_sel_next   = rccm_pkg::REFS_CNT;
                if (st.used && st.mode == rccm_pkg::MODE_TAKE && !st.ref_max)
                    state_next = S_INC;
                else if (st.used && st.mode == rccm_pkg::MODE_RELEASE && !st.ref_zero)
                    state_next = S_DEC;
                else if (st.used && st.mode == rccm_pkg::MODE_ABANDON && st.ref_zero)
                    state_next = S_FREE;
                else
                begin
                    res_status_next = rccm_pkg::ST_INVALID;
                    slot_sel_next   = rccm_pkg::SEL_IDX;
                    state_next      = S_RES;
                end
            end
            S_INC:
            begin
                // Count leaving zero joins the LRU list, leaving one drops off it
                op              = rccm_pkg::OP_INC;
                free_after_next = 1'b0;
                if (st.ref_zero)
                    state_next = S_AP1;
                else if (st.ref_one)
                    state_next = S_LRD;
                else
                    state_next = S_RES;
            end
            S_DEC:
            begin
                op = rccm_pkg::OP_DEC;
                if (st.ref_two)
                    state_next = S_AP1;
                else if (st.ref_one)
                begin
                    free_after_next = 1'b1;
                    state_next      = S_LRD;
                end
                else
                    state_next = S_RES;
            end
            S_AP1:
            begin
                op         = rccm_pkg::OP_AP1;
                state_next = S_AP2;
            end
            S_AP2:
            begin
                op         = rccm_pkg::OP_AP2;
                state_next = S_RES;
            end
            S_LRD:
            begin
                op         = rccm_pkg::OP_LRD;
                state_next = S_LRM;
            end
            S_LRM:
            begin
                op         = rccm_pkg::OP_LRM;
                state_next = free_after_reg ? S_FREE : S_RES;
            end
            S_FREE:
            begin
                op         = rccm_pkg::OP_FREE;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!st.out_busy)
                begin
                    op         = rccm_pkg::OP_RES;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            res_status_reg <= rccm_pkg::ST_INVALID;
            slot_sel_reg   <= rccm_pkg::SEL_ZERO;
            refs_sel_reg   <= rccm_pkg::REFS_ZERO;
            free_after_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            slot_sel_reg   <= slot_sel_next;
            refs_sel_reg   <= refs_sel_next;
            free_after_reg <= free_after_next;
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign cmd.op         = op;
    assign cmd.res_status = res_status_reg;
    assign cmd.slot_sel   = slot_sel_reg;
    assign cmd.refs_sel   = refs_sel_reg;
endmodule
`default_nettype wire

// ===== test/refcounted_chunk_cache_manager_checker.sv =====
// Result checker for the chunk cache manager: tracks slot state and compares every result.
`timescale 1ns / 100ps
`default_nettype none
module refcounted_chunk_cache_manager_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    input  wire         in_stall,
    input  wire  [1:0]  mode,
    input  wire  [23:0] chunk_key,
    input  wire  [7:0]  slot_index,
    input  wire         out_valid,
    input  wire         out_stall,
    input  wire  [2:0]  status,
    input  wire  [7:0]  slot_out,
    input  wire  [15:0] ref_out,
    input  wire         evicted,
    input  wire  [23:0] evicted_key,
    output int          fail_count,
    output int          pending_count,
    output int          hit_count,
    output int          evict_count
);

    localparam int NSLOT = 256;
    localparam int NIL = NSLOT;
    localparam logic [15:0] REF_TOP = 16'hFFFF;

    typedef struct packed {
        rccm_pkg::status_t st;
        logic [7:0]  slot;
        logic [15:0] refs;
        logic        ev;
        logic [23:0] ev_key;
    } cache_result_t;

    logic [23:0] key_tab [NSLOT];
    logic        used_tab [NSLOT];
    logic [15:0] refs_tab [NSLOT];
    int          free_link [NSLOT];
    int          idle_prev [NSLOT];
    int          idle_next [NSLOT];
    int          free_top, idle_head, idle_tail;
    cache_result_t expected_results [$];

    task automatic idle_append(input int s);
        idle_next[s] = NIL;
        idle_prev[s] = idle_tail;
        if (idle_tail < NIL) idle_next[idle_tail] = s;
        else idle_head = s;
        idle_tail = s;
    endtask

    task automatic idle_unlink(input int s);
        int p, n;
        p = idle_prev[s];
        n = idle_next[s];
        if (p < NIL) idle_next[p] = n;
        else idle_head = n;
        if (n < NIL) idle_prev[n] = p;
        else idle_tail = p;
    endtask

    task automatic slot_free(input int s);
        used_tab[s] = 1'b0;
        refs_tab[s] = '0;
        free_link[s] = free_top;
        free_top = s;
    endtask

    task automatic count_up(input int s);
        refs_tab[s]++;
        if (refs_tab[s] == 1) idle_append(s);
        else if (refs_tab[s] == 2) idle_unlink(s);
    endtask

    task automatic count_down(input int s);
        refs_tab[s]--;
        if (refs_tab[s] == 1) idle_append(s);
        else if (refs_tab[s] == 0)
        begin
            idle_unlink(s);
            slot_free(s);
        end
    endtask

    task automatic predict_cache_step(input rccm_pkg::mode_t m, input logic [23:0] k,
                                      input logic [7:0] idx);
        cache_result_t r;
        int hit, s, v;
        r = '{st: rccm_pkg::ST_INVALID, slot: idx, refs: '0, ev: 1'b0, ev_key: '0};
        if (m == rccm_pkg::MODE_REQUEST)
        begin
            hit = NIL;
            for (int i = 0; i < NSLOT; i++)
                if (hit == NIL && used_tab[i] && key_tab[i] == k) hit = i;
            if (hit < NIL)
            begin
                r.slot = hit[7:0];
                if (refs_tab[hit] == 0) r.st = rccm_pkg::ST_PENDING_HIT;
                else if (refs_tab[hit] == REF_TOP) r.st = rccm_pkg::ST_NO_SPACE;
                else
                begin
                    count_up(hit);
                    r.st = rccm_pkg::ST_READY_HIT;
                    hit_count++;
                end
                r.refs = refs_tab[hit];
            end
            else
            begin
                if (free_top >= NIL && idle_head < NIL)
                begin
                    v = idle_head;
                    r.ev = 1'b1;
                    r.ev_key = key_tab[v];
                    count_down(v);
                    evict_count++;
                end
                if (free_top >= NIL)
                begin
                    r.st = rccm_pkg::ST_NO_SPACE;
                    r.slot = '0;
                end
                else
                begin
                    s = free_top;
                    free_top = free_link[s];
                    used_tab[s] = 1'b1;
                    refs_tab[s] = '0;
                    key_tab[s] = k;
                    r.st = rccm_pkg::ST_MISS_ALLOC;
                    r.slot = s[7:0];
                end
            end
        end
        else
        begin
            s = int'(idx);
            r.refs = refs_tab[s];
            if (used_tab[s])
            begin
                if (m == rccm_pkg::MODE_TAKE && refs_tab[s] < REF_TOP)
                begin
                    count_up(s);
                    r.st = rccm_pkg::ST_DONE;
                end
                else if (m == rccm_pkg::MODE_RELEASE && refs_tab[s] > 0)
                begin
                    count_down(s);
                    r.st = rccm_pkg::ST_DONE;
                end
                else if (m == rccm_pkg::MODE_ABANDON && refs_tab[s] == 0)
                begin
                    slot_free(s);
                    r.st = rccm_pkg::ST_DONE;
                end
                r.refs = refs_tab[s];
            end
        end
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        cache_result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                key_tab[i] = '0;
                used_tab[i] = 1'b0;
                refs_tab[i] = '0;
                free_link[i] = i + 1;
                idle_prev[i] = 0;
                idle_next[i] = 0;
            end
            free_top = 0;
            idle_head = NIL;
            idle_tail = NIL;
            expected_results.delete();
            fail_count = 0;
            hit_count = 0;
            evict_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_cache_step(rccm_pkg::mode_t'(mode), chunk_key, slot_index);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, status", int'(status), 0);
                else
                begin
                    e = expected_results.pop_front();
                    if (status !== e.st)
                        report_mismatch("status", int'(status), int'(e.st));
                    if (slot_out !== e.slot)
                        report_mismatch("slot_out", int'(slot_out), int'(e.slot));
                    if (ref_out !== e.refs)
                        report_mismatch("ref_out", int'(ref_out), int'(e.refs));
                    if (evicted !== e.ev)
                        report_mismatch("evicted", int'(evicted), int'(e.ev));
                    if (evicted_key !== e.ev_key)
                        report_mismatch("evicted_key", int'(evicted_key), int'(e.ev_key));
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== test/refcounted_chunk_cache_manager_tb.sv =====
// Testbench top of the chunk cache manager: stimulus, flow control and verdict.
`timescale 1ns / 100ps
`default_nettype none
module refcounted_chunk_cache_manager_tb;

    localparam int RANDOM_ITEMS = 220;
    // Idle limit: a full key scan plus worst stall and gap, many times over;
    // also covers the clearing pass after reset and the long receiver hold-off.
    localparam int IDLE_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [1:0]  mode = rccm_pkg::MODE_REQUEST;
    logic [23:0] chunk_key = '0;
    logic [7:0]  slot_index = '0;
    logic        out_stall = 1'b0;
    wire         in_stall, out_valid, evicted;
    wire  [2:0]  status;
    wire  [7:0]  slot_out;
    wire  [15:0] ref_out;
    wire  [23:0] evicted_key;
    int          fail_count, pending_count, hit_count, evict_count;
    int          idle_cycles = 0;
    int          accepted = 0;
    int          hold_req = 0;
    logic [23:0] key_pool [16];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    refcounted_chunk_cache_manager u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .chunk_key(chunk_key), .slot_index(slot_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .slot_out(slot_out), .ref_out(ref_out),
        .evicted(evicted), .evicted_key(evicted_key)
    );

    refcounted_chunk_cache_manager_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .chunk_key(chunk_key), .slot_index(slot_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .slot_out(slot_out), .ref_out(ref_out),
        .evicted(evicted), .evicted_key(evicted_key),
        .fail_count(fail_count), .pending_count(pending_count),
        .hit_count(hit_count), .evict_count(evict_count)
    );

    // Offer one transaction, hold it until accepted, then drop valid for a random gap.
    // Zero gap keeps valid high straight into the next item with no lowering.
    task automatic send_item(input rccm_pkg::mode_t m, input logic [23:0] k,
                             input logic [7:0] idx);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        in_valid <= 1'b1;
        mode <= m;
        chunk_key <= k;
        slot_index <= idx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        accepted++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic stop_offering();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stall per result; a long hold-off when requested.
    initial
    begin
        int wait_n;
        int hold_seen;
        hold_seen = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
            if (wait_n != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
                while (!out_valid) @(posedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: any cycle with no accepted transaction on either channel counts.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("refcounted_chunk_cache_manager_tb failed");
            $finish;
        end
    end

    initial
    begin
        int r, s;
        logic [23:0] k;
        for (int i = 0; i < 16; i++) key_pool[i] = 24'($urandom());
        key_pool[0] = 24'h000000;
        key_pool[1] = 24'hFFFFFF;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: miss at key extremes, pending hit, take to ready, ready hit,
        // release, abandon, and the invalid cases.
        send_item(rccm_pkg::MODE_REQUEST, 24'h000000, 8'd0);   // miss, slot 0
        send_item(rccm_pkg::MODE_REQUEST, 24'hFFFFFF, 8'd0);   // miss, slot 1
        send_item(rccm_pkg::MODE_REQUEST, 24'h000000, 8'd0);   // pending hit
        send_item(rccm_pkg::MODE_TAKE, 24'h0, 8'd0);           // count 1, onto idle list
        send_item(rccm_pkg::MODE_REQUEST, 24'h000000, 8'hFF);  // ready hit, count 2
        send_item(rccm_pkg::MODE_RELEASE, 24'h0, 8'd0);        // back to 1
        send_item(rccm_pkg::MODE_ABANDON, 24'h0, 8'd0);        // invalid: count above zero
        send_item(rccm_pkg::MODE_ABANDON, 24'h0, 8'd1);        // abandon pending slot
        send_item(rccm_pkg::MODE_RELEASE, 24'h0, 8'd1);        // invalid: slot unused
        send_item(rccm_pkg::MODE_TAKE, 24'h0, 8'hFF);          // invalid: slot unused
        send_item(rccm_pkg::MODE_RELEASE, 24'h0, 8'd0);        // release to zero frees
        send_item(rccm_pkg::MODE_RELEASE, 24'h0, 8'd0);        // invalid: now unused
        send_item(rccm_pkg::MODE_REQUEST, 24'hA5A5A5, 8'd0);
        send_item(rccm_pkg::MODE_ABANDON, 24'h0, 8'd0);

        // Fill the whole pool with pending slots: nothing free, nothing idle.
        for (int i = 0; i < 256; i++)
            send_item(rccm_pkg::MODE_REQUEST, 24'(24'h100000 + i), 8'h00);
        send_item(rccm_pkg::MODE_REQUEST, 24'h654321, 8'd0);   // nothing idle: no space
        // Receiver pauses long while the sender keeps pushing: block backs up.
        hold_req++;
        for (int i = 0; i < 256; i++) send_item(rccm_pkg::MODE_TAKE, 24'h0, i[7:0]);
        send_item(rccm_pkg::MODE_REQUEST, 24'h5A5A5A, 8'd0);   // eviction of oldest idle
        send_item(rccm_pkg::MODE_REQUEST, 24'h100001, 8'd0);   // ready hit, count 2

        // Random: requests, mostly on a small key pool, and slot ops, mostly on low slots.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, 15)];
            if ($urandom_range(0, 9) == 0) k = 24'($urandom());
            s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
            if (r < 40) send_item(rccm_pkg::MODE_REQUEST, k, 8'($urandom_range(0, 255)));
            else if (r < 65) send_item(rccm_pkg::MODE_TAKE, k, s[7:0]);
            else if (r < 90) send_item(rccm_pkg::MODE_RELEASE, k, s[7:0]);
            else send_item(rccm_pkg::MODE_ABANDON, k, s[7:0]);
            if (n == 100) hold_req++;
        end
        stop_offering();

        while (pending_count != 0) @(posedge clk);
        repeat (300) @(posedge clk);

        $display("%0d transactions sent: %0d ready hits, %0d evictions,", accepted,
                 hit_count, evict_count);
        $display("pool filled and drained, receiver held off while the input backed up");
        if (fail_count == 0)
            $display("refcounted_chunk_cache_manager_tb passed");
        else
            $display("refcounted_chunk_cache_manager_tb failed");
        $finish;
    end

endmodule
`default_nettype wire
